### rtl/core/tlpm_pkg.sv
package tlpm_pkg;

  // Default size of the node pool.
  localparam int NODE_COUNT_DEF = 1024;

  // Ports at or above this count are rejected by an insert.
  localparam int PORT_COUNT = 8;

  // Field widths of the request and result channels.
  localparam int ADDR_W = 32;
  localparam int LEN_W  = 6;
  localparam int PORT_W = 3;

  // Deepest trie level; longer prefix lengths are clamped to it.
  localparam int MAX_DEPTH = 32;

  // Request kinds.
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // Result status codes.
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

endpackage

### rtl/core/trie_longest_prefix_match.sv
// IPv4 longest-prefix-match table built as a unibit binary trie in a pool of
// NODE_COUNT nodes. A request with kind insert adds a route (address,
// prefix_len, port); kind lookup returns the port of the longest stored
// prefix matching the address. Each request gives one result. The block
// takes one request at a time. The walk covers prefix_len trie levels for an
// insert and at most 32 for a lookup, visiting one node per cycle through a
// single node memory with a registered read port. The root node lives in
// flip-flops, so the table is usable right after reset with no clearing
// pass. When the pool runs out during an insert, the result has status 1 and
// nodes already added on that path remain.
module trie_longest_prefix_match
  import tlpm_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_kind,
  input  logic [ADDR_W-1:0] in_address,
  input  logic [LEN_W-1:0]  in_prefix_len,
  input  logic [PORT_W-1:0] in_port,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_found,
  output logic [PORT_W-1:0] out_out_port,
  output logic              out_status
);

  localparam int IDX_W = $clog2(NODE_COUNT);
  localparam int NF_W  = IDX_W + 1;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    idx_t              kid1;
    idx_t              kid0;
    logic              mark;
    logic [PORT_W-1:0] port;
  } node_t;

  state_t              state_r, state_nxt;
  logic                kind_r, kind_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [PORT_W-1:0]   port_r, port_nxt;
  logic                bad_port_r, bad_port_nxt;
  logic [LEN_W-1:0]    depth_r, depth_nxt;
  idx_t                cur_r, cur_nxt;
  logic                fresh_r, fresh_nxt;
  logic [NF_W-1:0]     next_free_r, next_free_nxt;
  logic                hit_r, hit_nxt;
  logic [PORT_W-1:0]   best_r, best_nxt;
  node_t               root_r, root_nxt;
  node_t               rd_q_r;
  logic                out_valid_r, out_valid_nxt;
  logic                out_found_r, out_found_nxt;
  logic [PORT_W-1:0]   out_port_r, out_port_nxt;
  logic                out_status_r, out_status_nxt;

  node_t               node_mem [NODE_COUNT];

  node_t               entry;
  node_t               upd;
  idx_t                child;
  logic                bit_sel;
  logic                out_free;
  logic                wr_en;
  logic                mem_we;
  idx_t                rd_addr;
  logic                finish;
  logic                fin_found;
  logic [PORT_W-1:0]   fin_port;
  logic                fin_status;
  logic                hit_now;
  logic [PORT_W-1:0]   best_now;

  // The node under the walk: root flops, a fresh all-empty node, or memory.
  assign entry   = (cur_r == '0) ? root_r : (fresh_r ? '0 : rd_q_r);
  assign bit_sel = addr_r[ADDR_W-1];
  assign child   = bit_sel ? entry.kid1 : entry.kid0;
  assign out_free = !out_valid_r || !out_stall;
  assign hit_now  = hit_r | entry.mark;
  assign best_now = entry.mark ? entry.port : best_r;

  // Sequencer: one trie level per cycle.
  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    addr_nxt       = addr_r;
    len_nxt        = len_r;
    port_nxt       = port_r;
    bad_port_nxt   = bad_port_r;
    depth_nxt      = depth_r;
    cur_nxt        = cur_r;
    fresh_nxt      = fresh_r;
    next_free_nxt  = next_free_r;
    hit_nxt        = hit_r;
    best_nxt       = best_r;
    out_valid_nxt  = out_valid_r;
    out_found_nxt  = out_found_r;
    out_port_nxt   = out_port_r;
    out_status_nxt = out_status_r;
    upd            = entry;
    wr_en          = 1'b0;
    rd_addr        = cur_r;
    finish         = 1'b0;
    fin_found      = 1'b0;
    fin_port       = '0;
    fin_status     = STATUS_OK;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt    = ST_WALK;
          kind_nxt     = in_kind;
          addr_nxt     = in_address;
          len_nxt      = (in_prefix_len > LEN_W'(MAX_DEPTH)) ? LEN_W'(MAX_DEPTH)
                                                            : in_prefix_len;
          port_nxt     = in_port;
          bad_port_nxt = (int'(in_port) >= PORT_COUNT);
          depth_nxt    = '0;
          cur_nxt      = '0;
          fresh_nxt    = 1'b0;
          hit_nxt      = 1'b0;
          best_nxt     = '0;
        end
      end

      ST_WALK: begin
        if (kind_r == KIND_LOOKUP) begin
          // Lookup: remember the deepest marked node, stop at a missing child or at MAX_DEPTH.
          if (depth_r == LEN_W'(MAX_DEPTH) || child == '0 ||
              {1'b0, child} >= NF_W'(NODE_COUNT)) begin
            if (out_free) begin
              finish    = 1'b1;
              fin_found = hit_now;
              fin_port  = hit_now ? best_now : '0;
            end
          end else begin
            hit_nxt   = hit_now;
            best_nxt  = best_now;
            cur_nxt   = child;
            rd_addr   = child;
            depth_nxt = depth_r + LEN_W'(1);
            addr_nxt  = addr_r << 1;
          end
        end else if (bad_port_r) begin
          // An insert with a port out of range changes nothing.
          if (out_free) begin
            finish = 1'b1;
          end
        end else if (depth_r == len_r) begin
          // Reached the prefix depth: mark the node with the port.
          if (out_free) begin
            finish   = 1'b1;
            upd.mark = 1'b1;
            upd.port = port_r;
            wr_en    = 1'b1;
          end
        end else if (child != '0) begin
          // Existing child: follow it.
          cur_nxt   = child;
          rd_addr   = child;
          depth_nxt = depth_r + LEN_W'(1);
          addr_nxt  = addr_r << 1;
        end else if (next_free_r >= NF_W'(NODE_COUNT)) begin
          // Pool exhausted; a freshly allocated node is still written empty.
          if (out_free) begin
            finish     = 1'b1;
            fin_status = STATUS_FULL;
            wr_en      = fresh_r;
          end
        end else begin
          // Allocate the next free node and link it in.
          if (bit_sel) begin
            upd.kid1 = next_free_r[IDX_W-1:0];
          end else begin
            upd.kid0 = next_free_r[IDX_W-1:0];
          end
          wr_en         = 1'b1;
          cur_nxt       = next_free_r[IDX_W-1:0];
          fresh_nxt     = 1'b1;
          next_free_nxt = next_free_r + NF_W'(1);
          depth_nxt     = depth_r + LEN_W'(1);
          addr_nxt      = addr_r << 1;
        end

        if (finish) begin
          state_nxt      = ST_IDLE;
          out_valid_nxt  = 1'b1;
          out_found_nxt  = fin_found;
          out_port_nxt   = fin_port;
          out_status_nxt = fin_status;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Root updates go to the flops, all other nodes to the memory.
  assign mem_we   = wr_en && (cur_r != '0);
  assign root_nxt = (wr_en && (cur_r == '0)) ? upd : root_r;

  // Node memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      node_mem[cur_r] <= upd;
    end
    rd_q_r <= node_mem[rd_addr];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      next_free_r <= NF_W'(1);
      root_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      next_free_r <= next_free_nxt;
      root_r      <= root_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request and result payload.
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    addr_r       <= addr_nxt;
    len_r        <= len_nxt;
    port_r       <= port_nxt;
    bad_port_r   <= bad_port_nxt;
    depth_r      <= depth_nxt;
    cur_r        <= cur_nxt;
    fresh_r      <= fresh_nxt;
    hit_r        <= hit_nxt;
    best_r       <= best_nxt;
    out_found_r  <= out_found_nxt;
    out_port_r   <= out_port_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_stall     = (state_r != ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_out_port = out_port_r;
  assign out_status   = out_status_r;

`ifndef NO_ASSERTIONS
  // The allocation pointer never passes the pool size.
  a_nf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_free_r <= NF_W'(NODE_COUNT))
    else $error("next_free beyond pool size");

  // Nodes are allocated one at a time.
  a_nf_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (next_free_r != $past(next_free_r))) |->
      (next_free_r == $past(next_free_r) + NF_W'(1)))
    else $error("next_free moved by more than one");

  // Memory writes only touch allocated nodes.
  a_mem_we: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ({1'b0, cur_r} < next_free_r))
    else $error("write to an unallocated node");

  // An insert never walks below its prefix depth.
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK && kind_r == KIND_INSERT) |-> (depth_r <= len_r))
    else $error("insert walked past prefix length");

  // A result never reports both a match and an exhausted pool.
  a_out_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_found_r && out_status_r == STATUS_FULL))
    else $error("found and pool-full together");
`endif

endmodule

### verif/tb_trie_longest_prefix_match.sv
`timescale 1ns / 1ps

module tb_trie_longest_prefix_match;
  import tlpm_pkg::*;

  localparam int NODES        = NODE_COUNT_DEF;
  localparam int BASE_COUNT   = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 1000000;

  // One result as the block reports it.
  typedef struct packed {
    logic              found;
    logic [PORT_W-1:0] port;
    logic              status;
  } lpm_result_t;

  logic              clk           = 1'b0;
  logic              rst_n         = 1'b0;
  logic              in_valid      = 1'b0;
  logic              in_stall;
  logic              in_kind       = KIND_INSERT;
  logic [ADDR_W-1:0] in_address    = '0;
  logic [LEN_W-1:0]  in_prefix_len = '0;
  logic [PORT_W-1:0] in_port       = '0;
  logic              out_valid;
  logic              out_stall     = 1'b0;
  logic              out_found;
  logic [PORT_W-1:0] out_out_port;
  logic              out_status;

  // Shadow copy of the trie that predicts every answer.
  int unsigned       trie_child [NODES][2];
  bit                trie_marked [NODES];
  logic [PORT_W-1:0] trie_port [NODES];
  int unsigned       trie_next_free;

  lpm_result_t       pending_results [$];
  lpm_result_t       want_result;
  logic [ADDR_W-1:0] route_bases [BASE_COUNT];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  logic hold_go      = 1'b0;
  int fail_count     = 0;
  int cycle_count    = 0;

  trie_longest_prefix_match dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_address    (in_address),
    .in_prefix_len (in_prefix_len),
    .in_port       (in_port),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_found     (out_found),
    .out_out_port  (out_out_port),
    .out_status    (out_status)
  );

  always #2 clk = ~clk;

  // Mask of the k lowest address bits.
  function automatic logic [ADDR_W-1:0] low_mask(input int k);
    return ~({ADDR_W{1'b1}} << k);
  endfunction

  // Route insert: walk the prefix, allocating missing nodes in pool order.
  function automatic logic predict_insert(input logic [ADDR_W-1:0] addr,
                                          input logic [LEN_W-1:0] len,
                                          input logic [PORT_W-1:0] prt);
    int unsigned cur;
    int unsigned nxt;
    int unsigned depth_limit;
    logic bit_val;
    cur = 0;
    depth_limit = (len > MAX_DEPTH) ? MAX_DEPTH : len;
    // Ports past the table size are refused without touching the trie.
    if (prt >= PORT_COUNT) return STATUS_OK;
    for (int unsigned depth = 0; depth < depth_limit; depth++) begin
      bit_val = addr[ADDR_W-1-depth];
      nxt = trie_child[cur][bit_val];
      if (nxt == 0) begin
        if (trie_next_free >= NODES) return STATUS_FULL;
        nxt = trie_next_free;
        trie_next_free++;
        trie_child[nxt][0] = 0;
        trie_child[nxt][1] = 0;
        trie_marked[nxt] = 1'b0;
        trie_port[nxt] = '0;
        trie_child[cur][bit_val] = nxt;
      end
      cur = nxt;
    end
    trie_marked[cur] = 1'b1;
    trie_port[cur] = prt;
    return STATUS_OK;
  endfunction

  // Destination lookup: the deepest marked node on the path wins.
  function automatic lpm_result_t predict_lookup(input logic [ADDR_W-1:0] addr);
    lpm_result_t r;
    int unsigned cur;
    int unsigned nxt;
    r = '0;
    cur = 0;
    r.found = trie_marked[0];
    r.port = trie_port[0];
    for (int unsigned depth = 0; depth < MAX_DEPTH; depth++) begin
      nxt = trie_child[cur][addr[ADDR_W-1-depth]];
      if (nxt == 0 || nxt >= NODES) break;
      cur = nxt;
      if (trie_marked[cur]) begin
        r.found = 1'b1;
        r.port = trie_port[cur];
      end
    end
    if (!r.found) r.port = '0;
    return r;
  endfunction

  function automatic lpm_result_t predict_request(input logic kind,
                                                  input logic [ADDR_W-1:0] addr,
                                                  input logic [LEN_W-1:0] len,
                                                  input logic [PORT_W-1:0] prt);
    lpm_result_t r;
    r = '0;
    if (kind == KIND_INSERT) begin
      r.status = predict_insert(addr, len, prt);
    end else begin
      r = predict_lookup(addr);
    end
    return r;
  endfunction

  // Offer one request, holding it until the block takes it, then record the
  // answer it must produce.
  task automatic send_request(input logic kind, input logic [ADDR_W-1:0] addr,
                              input logic [LEN_W-1:0] len,
                              input logic [PORT_W-1:0] prt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_address    <= addr;
    in_prefix_len <= len;
    in_port       <= prt;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_request(kind, addr, len, prt));
  endtask

  // Stop offering requests until every answer is back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_table();
    send_request(KIND_LOOKUP, 32'h0000_0000, 6'd0, 3'd0);
    send_request(KIND_LOOKUP, 32'hFFFF_FFFF, 6'd63, 3'd7);
  endtask

  // Host routes at both ends of the address space and a /1.
  task automatic test_prefix_extremes();
    send_request(KIND_INSERT, 32'hFFFF_FFFF, 6'd32, 3'd7);
    send_request(KIND_INSERT, 32'h0000_0000, 6'd32, 3'd0);
    send_request(KIND_INSERT, 32'h8000_0000, 6'd1, 3'd3);
    send_request(KIND_LOOKUP, 32'hFFFF_FFFF, 6'd0, 3'd0);
    send_request(KIND_LOOKUP, 32'hFFFF_FFFE, 6'd0, 3'd0);
    send_request(KIND_LOOKUP, 32'h0000_0000, 6'd0, 3'd0);
    send_request(KIND_LOOKUP, 32'h0000_0001, 6'd0, 3'd0);
    send_request(KIND_LOOKUP, 32'h7FFF_FFFF, 6'd0, 3'd0);
  endtask

  // Nested routes: the longest one that covers the destination wins.
  task automatic test_nested_prefixes();
    send_request(KIND_INSERT, 32'h0A00_0000, 6'd8, 3'd1);
    send_request(KIND_INSERT, 32'h0A01_0000, 6'd16, 3'd2);
    send_request(KIND_INSERT, 32'h0A01_02FF, 6'd24, 3'd4);
    send_request(KIND_LOOKUP, 32'h0A01_0203, 6'd0, 3'd0);
    send_request(KIND_LOOKUP, 32'h0A01_0909, 6'd0, 3'd0);
    send_request(KIND_LOOKUP, 32'h0A09_0909, 6'd0, 3'd0);
    send_request(KIND_LOOKUP, 32'h0B00_0000, 6'd0, 3'd0);
  endtask

  // Inserting the same route again replaces its port.
  task automatic test_repeated_route();
    send_request(KIND_INSERT, 32'h0A01_0000, 6'd16, 3'd6);
    send_request(KIND_LOOKUP, 32'h0A01_0505, 6'd0, 3'd0);
  endtask

  // Prefix lengths past 32 behave as host routes. The port field is only
  // three bits wide, so an out-of-range port cannot be requested.
  task automatic test_long_prefix_len();
    send_request(KIND_INSERT, 32'hC0A8_0101, 6'd63, 3'd2);
    send_request(KIND_INSERT, 32'hC0A8_0102, 6'd33, 3'd5);
    send_request(KIND_LOOKUP, 32'hC0A8_0101, 6'd0, 3'd0);
    send_request(KIND_LOOKUP, 32'hC0A8_0102, 6'd0, 3'd0);
    send_request(KIND_LOOKUP, 32'hC0A8_0103, 6'd0, 3'd0);
  endtask

  // A /0 route marks the root, so every destination now matches.
  task automatic test_default_route();
    send_request(KIND_INSERT, $urandom, 6'd0, 3'd5);
    send_request(KIND_LOOKUP, 32'h0B00_0000, 6'd0, 3'd0);
    send_request(KIND_LOOKUP, 32'h0A01_0203, 6'd0, 3'd0);
    send_request(KIND_LOOKUP, $urandom, LEN_W'($urandom_range(63)),
                 PORT_W'($urandom_range(7)));
  endtask

  // Random traffic clustered around a few networks so that lookups hit
  // deep routes and the pool lasts for most of the run.
  task automatic random_requests(input int count, input bit allow_default);
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    int pick;
    int min_len;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      min_len = allow_default ? 0 : 1;
      addr = route_bases[$urandom_range(BASE_COUNT-1)];
      if (pick < 35) begin
        if (pick < 5) begin
          // Short route anywhere in the address space.
          addr = $urandom;
          len = LEN_W'($urandom_range(8, min_len));
        end else begin
          // Route on a known network, sometimes a sibling near the bottom.
          if ($urandom_range(99) < 15) addr = addr ^ (32'd1 << $urandom_range(5));
          if ($urandom_range(9) == 0) len = LEN_W'($urandom_range(63, 33));
          else len = LEN_W'($urandom_range(32, min_len));
        end
        // Bits past the prefix are don't-care; fill them with noise.
        if (len < MAX_DEPTH) begin
          addr = (addr & ~low_mask(MAX_DEPTH - len)) |
                 ($urandom & low_mask(MAX_DEPTH - len));
        end
        send_request(KIND_INSERT, addr, len, PORT_W'($urandom_range(7)));
      end else begin
        if (pick < 85) addr = addr ^ ($urandom & low_mask($urandom_range(32)));
        else addr = $urandom;
        send_request(KIND_LOOKUP, addr, LEN_W'($urandom_range(63)),
                     PORT_W'($urandom_range(7)));
      end
    end
  endtask

  // The result side holds off while requests keep coming, then the sender
  // pauses until the block has answered everything.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    in_valid <= 1'b0;
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    for (int i = 0; i < 12; i++) begin
      send_request(KIND_LOOKUP, route_bases[i % BASE_COUNT] ^ low_mask(i), 6'd0, 3'd0);
    end
    wait_drained();
  endtask

  // Fill the pool with host routes, then check refused and accepted inserts.
  task automatic test_pool_exhaustion();
    logic [ADDR_W-1:0] addr;
    int tries;
    tries = 0;
    addr = '0;
    while (trie_next_free < NODES && tries < 200) begin
      addr = $urandom;
      send_request(KIND_INSERT, addr, 6'd32, PORT_W'($urandom_range(7)));
      tries++;
    end
    for (int i = 0; i < 3; i++) begin
      addr = $urandom;
      send_request(KIND_INSERT, addr, 6'd32, PORT_W'($urandom_range(7)));
    end
    send_request(KIND_LOOKUP, addr, 6'd0, 3'd0);
    // Routes whose nodes exist still go in once the pool is full.
    send_request(KIND_INSERT, 32'h0A01_0000, 6'd16, 3'd3);
    send_request(KIND_LOOKUP, 32'h0A01_024D, 6'd0, 3'd0);
    send_request(KIND_LOOKUP, 32'h0A01_774D, 6'd0, 3'd0);
    send_request(KIND_INSERT, 32'h0000_0000, 6'd0, 3'd1);
    send_request(KIND_LOOKUP, $urandom, 6'd0, 3'd0);
  endtask

  // Cycle budget for the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Long receiver hold-off, counted here in cycles.
  always @(posedge clk) begin
    if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result-side stall: random, or forced during a hold-off.
  always @(posedge clk) begin
    out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
  end

  // Compare every accepted result with the oldest expected answer.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: found %0d port %0d status %0d",
               out_found, out_out_port, out_status);
        fail_count++;
      end else begin
        want_result = pending_results.pop_front();
        if (out_found !== want_result.found) begin
          $error("found mismatch: expected %0d, actual %0d", want_result.found, out_found);
          fail_count++;
        end
        if (out_out_port !== want_result.port) begin
          $error("out_port mismatch: expected %0d, actual %0d",
                 want_result.port, out_out_port);
          fail_count++;
        end
        if (out_status !== want_result.status) begin
          $error("status mismatch: expected %0d, actual %0d",
                 want_result.status, out_status);
          fail_count++;
        end
      end
    end
  end

  initial begin
    // The table starts with an empty root and node 1 next in line.
    for (int i = 0; i < NODES; i++) begin
      trie_child[i][0] = 0;
      trie_child[i][1] = 0;
      trie_marked[i] = 1'b0;
      trie_port[i] = '0;
    end
    trie_next_free = 1;
    for (int i = 0; i < BASE_COUNT; i++) route_bases[i] = $urandom;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_prefix_extremes();
    test_nested_prefixes();
    test_repeated_route();
    test_long_prefix_len();

    // Random traffic, first with no default route so misses stay possible.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_requests(350, 1'b0);
    send_idle_pct = 76;
    random_requests(350, 1'b0);
    test_default_route();
    send_idle_pct = 0;
    recv_stall_pct = 76;
    random_requests(350, 1'b1);
    send_idle_pct = 16;
    recv_stall_pct = 16;
    random_requests(350, 1'b1);

    test_output_backpressure();
    send_idle_pct = 16;
    recv_stall_pct = 16;
    test_pool_exhaustion();
    random_requests(60, 1'b1);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
